// File: rtl/core/silcd_pkg.sv
package silcd_pkg;

    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] ID_DISP  = 8'hD1;
    localparam logic [7:0] ID_STAT  = 8'hD2;
    localparam logic [7:0] ID_TEMP  = 8'hD3;
    localparam logic [7:0] ID_VOLT  = 8'hD4;
    localparam logic [7:0] ID_VERS  = 8'hD5;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ID   = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  message_id;
        logic [1:0]  payload_length;
        logic [7:0]  payload_byte0;
        logic [7:0]  payload_byte1;
        logic [7:0]  payload_byte2;
        logic [31:0] frame_sequence;
    } frame_t;

    // Payload length of a known id, zero for an unknown one.
    function automatic logic [1:0] id_length(input logic [7:0] id);
        logic [1:0] len;
        unique case (id)
            ID_DISP: len = 2'd3;
            ID_STAT: len = 2'd3;
            ID_TEMP: len = 2'd1;
            ID_VOLT: len = 2'd2;
            ID_VERS: len = 2'd3;
            default: len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/core/sync_id_length_checksum_deframer_unit.sv
// Frame parser for a received serial byte stream.
// Input channel: one rx_byte per transaction (in_valid / in_stall). The
// parser hunts for header 0x55, takes the id, collects 1 to 3 payload bytes
// by id and checks an 8-bit sum of header, id and payload against the
// trailing checksum byte.
// Output channel: one transaction per frame whose checksum matches, with id,
// length, payload (unused bytes zero) and a wrapping frame sequence number.
// Bad ids and checksum mismatches produce nothing.
// Throughput: one byte per cycle while in_stall is low; the parser updates
// its state from each byte between the input register and the result buffer.
// A result is registered: its checksum byte passes the input register, and
// the result then enters the output or skid register before out_valid rises.
// Reset clears the input valid bit, the parser state, the frame counter and
// the result buffer valid bits; the block then hunts for a header.
// When the receiver stalls, the result is held in the output register and a
// second result can wait in the skid register; only when both are full does
// in_stall rise.
module sync_id_length_checksum_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  message_id,
    output logic [1:0]  payload_length,
    output logic [7:0]  payload_byte0,
    output logic [7:0]  payload_byte1,
    output logic [7:0]  payload_byte2,
    output logic [31:0] frame_sequence
);
    import silcd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       fire;
    logic       buf_full;
    logic       res_valid;
    frame_t     res;
    frame_t     out_data;

    assign fire     = in_valid_reg && !buf_full;
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    silcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    silcd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

    assign message_id     = out_data.message_id;
    assign payload_length = out_data.payload_length;
    assign payload_byte0  = out_data.payload_byte0;
    assign payload_byte1  = out_data.payload_byte1;
    assign payload_byte2  = out_data.payload_byte2;
    assign frame_sequence = out_data.frame_sequence;

endmodule

// File: rtl/core/silcd_parser.sv
module silcd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output silcd_pkg::frame_t     res
);
    import silcd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  current_id_reg, current_id_next;
    logic [1:0]  expected_length_reg, expected_length_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [31:0] accepted_count_reg, accepted_count_next;
    logic [7:0]  payload_store_reg [3];
    logic [1:0]  len;
    logic [2:0]  index_inc;
    logic [31:0] count_inc;

    assign len       = id_length(rx_byte);
    assign index_inc = {1'b0, byte_index_reg} + 3'd1;
    assign count_inc = accepted_count_reg + 32'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        current_id_next      = current_id_reg;
        expected_length_next = expected_length_reg;
        byte_index_next      = byte_index_reg;
        running_sum_next     = running_sum_reg;
        accepted_count_next  = accepted_count_reg;
        res_valid            = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    running_sum_next = rx_byte;
                    phase_next       = PH_ID;
                end
            end
            PH_ID:
            begin
                current_id_next = rx_byte;
                if (len == 2'd0)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    expected_length_next = len;
                    running_sum_next     = (running_sum_reg + rx_byte) & BYTE_MASK;
                    byte_index_next      = 2'd0;
                    phase_next           = PH_DATA;
                end
            end
            PH_DATA:
            begin
                byte_index_next  = index_inc[1:0];
                running_sum_next = (running_sum_reg + rx_byte) & BYTE_MASK;
                if (index_inc >= {1'b0, expected_length_reg})
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                phase_next = PH_HUNT;
                if (running_sum_reg == rx_byte)
                begin
                    accepted_count_next = count_inc;
                    res_valid           = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
        if (!fire)
        begin
            res_valid = 1'b0;
        end
    end

    always_comb
    begin
        res.message_id     = current_id_reg;
        res.payload_length = expected_length_reg;
        res.payload_byte0  = payload_store_reg[0];
        res.payload_byte1  = (expected_length_reg >= 2'd2) ? payload_store_reg[1] : 8'd0;
        res.payload_byte2  = (expected_length_reg == 2'd3) ? payload_store_reg[2] : 8'd0;
        res.frame_sequence = count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            current_id_reg      <= 8'd0;
            expected_length_reg <= 2'd0;
            byte_index_reg      <= 2'd0;
            running_sum_reg     <= 8'd0;
            accepted_count_reg  <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            current_id_reg      <= current_id_next;
            expected_length_reg <= expected_length_next;
            byte_index_reg      <= byte_index_next;
            running_sum_reg     <= running_sum_next;
            accepted_count_reg  <= accepted_count_next;
        end
    end

    // Payload bytes are only read after this frame has written them.
    always_ff @(posedge clk)
    begin
        if (fire && phase_reg == PH_DATA && byte_index_reg != 2'd3)
        begin
            payload_store_reg[byte_index_reg] <= rx_byte;
        end
    end

endmodule

// File: rtl/core/silcd_out_buf.sv
module silcd_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  silcd_pkg::frame_t     push_data,
    output logic                  full,
    output logic                  valid,
    input  logic                  stall,
    output silcd_pkg::frame_t     data
);
    import silcd_pkg::*;

    logic   out_valid_reg;
    logic   skid_valid_reg;
    frame_t out_data_reg;
    frame_t skid_data_reg;
    logic   pop;

    assign pop   = out_valid_reg && !stall;
    assign full  = out_valid_reg && skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import silcd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTE_TARGET = 950;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        frame_t     want;
    } byte_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  message_id;
    logic [1:0]  payload_length;
    logic [7:0]  payload_byte0;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte2;
    logic [31:0] frame_sequence;

    sync_id_length_checksum_deframer_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .message_id     (message_id),
        .payload_length (payload_length),
        .payload_byte0  (payload_byte0),
        .payload_byte1  (payload_byte1),
        .payload_byte2  (payload_byte2),
        .frame_sequence (frame_sequence)
    );

    always #1 clk = ~clk;

    // Parser shadow state
    phase_t      hunt_phase = PH_HUNT;
    logic [7:0]  frame_id = 8'h00;
    logic [1:0]  frame_len = 2'd0;
    logic [1:0]  fill_idx = 2'd0;
    logic [7:0]  payload_seen [3];
    logic [7:0]  sum8 = 8'h00;
    logic [31:0] frames_accepted = 32'd0;

    frame_t      frames_due [$];
    frame_t      no_frame = '0;
    int          errors = 0;
    int          bytes_fed = 0;
    int          frames_checked = 0;
    int          cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          long_hold_done = 1'b0;

    logic [7:0]  known_ids [5] = '{ID_DISP, ID_STAT, ID_TEMP, ID_VOLT, ID_VERS};

    // Directed bytes; typed rows close a frame whose result is plain to see.
    byte_row_t   byte_rows [29] = '{
        // short frame, zero payload
        {8'h55, 1'b0, 66'd0},
        {ID_TEMP, 1'b0, 66'd0},
        {8'h00, 1'b0, 66'd0},
        {8'h28, 1'b1, {ID_TEMP, 2'd1, 8'h00, 8'h00, 8'h00, 32'd1}},
        // long frame, all-ones payload
        {8'h55, 1'b0, 66'd0},
        {ID_DISP, 1'b0, 66'd0},
        {8'hFF, 1'b0, 66'd0},
        {8'hFF, 1'b0, 66'd0},
        {8'hFF, 1'b0, 66'd0},
        {8'h23, 1'b1, {ID_DISP, 2'd3, 8'hFF, 8'hFF, 8'hFF, 32'd2}},
        // unknown id
        {8'h55, 1'b0, 66'd0},
        {8'hFF, 1'b0, 66'd0},
        // header value inside the payload
        {8'h55, 1'b0, 66'd0},
        {ID_VOLT, 1'b0, 66'd0},
        {8'h55, 1'b0, 66'd0},
        {8'hAA, 1'b0, 66'd0},
        {8'h28, 1'b1, {ID_VOLT, 2'd2, 8'h55, 8'hAA, 8'h00, 32'd3}},
        // bad checksum that equals the header value
        {8'h55, 1'b0, 66'd0},
        {ID_STAT, 1'b0, 66'd0},
        {8'h01, 1'b0, 66'd0},
        {8'h02, 1'b0, 66'd0},
        {8'h03, 1'b0, 66'd0},
        {8'h55, 1'b0, 66'd0},
        {8'h55, 1'b0, 66'd0},
        {ID_VERS, 1'b0, 66'd0},
        {8'h80, 1'b0, 66'd0},
        {8'h40, 1'b0, 66'd0},
        {8'h20, 1'b0, 66'd0},
        {8'h0A, 1'b0, 66'd0}
    };

    // Advance the shadow parser by one byte; return 1 when a frame's checksum matches.
    function automatic bit parse_byte(input logic [7:0] b, output frame_t f);
        logic [1:0] len;
        f = '0;
        case (hunt_phase)
            PH_HUNT:
                if (b == HDR_BYTE)
                begin
                    sum8 = b;
                    hunt_phase = PH_ID;
                end
            PH_ID:
            begin
                frame_id = b;
                case (b)
                    ID_DISP, ID_STAT, ID_VERS: len = 2'd3;
                    ID_VOLT:                   len = 2'd2;
                    ID_TEMP:                   len = 2'd1;
                    default:                   len = 2'd0;
                endcase
                if (len == 2'd0)
                    hunt_phase = PH_HUNT;
                else
                begin
                    frame_len = len;
                    sum8 = sum8 + b;
                    fill_idx = 2'd0;
                    hunt_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                payload_seen[fill_idx] = b;
                fill_idx = fill_idx + 2'd1;
                sum8 = sum8 + b;
                if (fill_idx >= frame_len)
                    hunt_phase = PH_SUM;
            end
            default:
            begin
                hunt_phase = PH_HUNT;
                if (sum8 == b)
                begin
                    frames_accepted = frames_accepted + 32'd1;
                    f.message_id = frame_id;
                    f.payload_length = frame_len;
                    f.payload_byte0 = payload_seen[0];
                    f.payload_byte1 = (frame_len >= 2'd2) ? payload_seen[1] : 8'h00;
                    f.payload_byte2 = (frame_len == 2'd3) ? payload_seen[2] : 8'h00;
                    f.frame_sequence = frames_accepted;
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return HDR_BYTE;
        else if (r == 1)
            return 8'h00;
        else if (r == 2)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input bit typed, input frame_t want);
        int gap;
        bit hit;
        frame_t f;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_fed++;
        hit = parse_byte(b, f);
        if (typed)
            frames_due.push_back(want);
        else if (hit)
            frames_due.push_back(f);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin : drive_bytes
        logic [7:0] b;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (byte_rows[i])
            send_byte(byte_rows[i].rx, byte_rows[i].typed, byte_rows[i].want);

        while (bytes_fed < BYTE_TARGET)
        begin
            tx_calm = ($urandom_range(0, 9) == 0);
            // stray bytes between frames, a header among them at times
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(($urandom_range(0, 4) == 0) ? HDR_BYTE : 8'($urandom),
                              1'b0, no_frame);
            send_byte(HDR_BYTE, 1'b0, no_frame);
            if ($urandom_range(0, 99) < 8)
                b = 8'($urandom);
            else
                b = known_ids[$urandom_range(0, 4)];
            send_byte(b, 1'b0, no_frame);
            while (hunt_phase == PH_DATA)
                send_byte(pick_payload(), 1'b0, no_frame);
            if (hunt_phase == PH_SUM)
            begin
                if ($urandom_range(0, 99) < 80)
                    b = sum8;
                else
                    b = sum8 ^ 8'($urandom_range(1, 255));
                send_byte(b, 1'b0, no_frame);
            end
        end
        in_valid <= 1'b0;

        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Receiver stalls, with one long hold once traffic is flowing.
    initial
    begin : drive_stall
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0)
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_calm = !rx_calm;
                if (!long_hold_done && frames_checked >= 12)
                begin
                    hold_left = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
                else
                    hold_left = pick_gap(rx_calm);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_frames
        frame_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $error("frame with no expectation: message_id %0h frame_sequence %0h",
                       message_id, frame_sequence);
                errors++;
            end
            else
            begin
                due = frames_due.pop_front();
                check_field("message_id", due.message_id, message_id);
                check_field("payload_length", due.payload_length, payload_length);
                check_field("payload_byte0", due.payload_byte0, payload_byte0);
                check_field("payload_byte1", due.payload_byte1, payload_byte1);
                check_field("payload_byte2", due.payload_byte2, payload_byte2);
                check_field("frame_sequence", due.frame_sequence, frame_sequence);
                frames_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/silcd_pkg.sv
rtl/core/silcd_parser.sv
rtl/core/silcd_out_buf.sv
rtl/core/sync_id_length_checksum_deframer_unit.sv
tb/tb.sv
